// ===== hw/rtl/csrmv_pkg.sv =====
package csrmv_pkg;

    // sizes of the stores
    localparam int MAX_ROWS     = 64;
    localparam int MAX_COLS     = 64;
    localparam int MAX_NONZEROS = 4096;

    // derived widths
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int NZ_AW  = $clog2(MAX_NONZEROS);
    localparam int CNT_W  = NZ_AW + 1;
    localparam int SIZE_W = 7;
    localparam int VAL_W  = 16;
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = 40;
    localparam int IDX_W  = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

    // item kinds carried in tuser
    localparam logic ITEM_MATRIX = 1'b0;
    localparam logic ITEM_VECTOR = 1'b1;

    // one stored nonzero: column on top, value below
    typedef struct packed {
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } nz_entry_t;

    // control from the sequencer to the multiply-accumulate pipeline
    typedef struct packed {
        logic issue;
        logic clear;
    } mac_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_ROWEND,
        S_RUN,
        S_DRAIN,
        S_OUT
    } state_t;

endpackage

// ===== hw/rtl/csrmv_ram.sv =====
module csrmv_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/csrmv_mac.sv =====
module csrmv_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  csrmv_pkg::mac_ctrl_t              ctrl,
    input  csrmv_pkg::nz_entry_t              nz_rdata,
    input  logic signed [csrmv_pkg::VAL_W-1:0] vec_rdata,
    output logic [csrmv_pkg::COL_W-1:0]       vec_raddr,
    output logic signed [csrmv_pkg::ACC_W-1:0] acc,
    output logic                              busy
);

    import csrmv_pkg::*;

    logic                     p1_reg, p2_reg, p3_reg;
    logic signed [VAL_W-1:0]  val_reg, val_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    // stage valid bits: nonzero read, vector read, product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= 1'b0;
            p2_reg <= 1'b0;
            p3_reg <= 1'b0;
        end
        else
        begin
            p1_reg <= ctrl.issue;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
        end
    end

    // vector element is addressed by the column just read
    assign vec_raddr = nz_rdata.col;

    // datapath stages
    always_comb
    begin
        val_next  = p1_reg ? nz_rdata.value : val_reg;
        prod_next = p2_reg ? val_reg * vec_rdata : prod_reg;
        acc_next  = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (p3_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc  = acc_reg;
    assign busy = p1_reg | p2_reg | p3_reg;

endmodule

// ===== hw/rtl/csr_sparse_matrix_vector_multiply.sv =====
// channel    | direction | fields (lowest bit first)
// s_axis     | in        | tdata: sample_value[15:0]; tuser: func
// m_axis     | out       | tdata: row_number[5:0], row_product[45:6], zero pad; tlast: last_row
// cfg        | in        | cfg_index: register index, cfg_data: value
//
// matrix entries and vector elements are taken in the idle state while no cfg write is pending
// the final vector element starts a walk over the rows, with
// one nonzero read per cycle through the nonzero memory port
// a result waits in the output register; the walk stalls only when it is still full
// reset clears counters and flags, the memories are written before any read
module csr_sparse_matrix_vector_multiply (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [15:0]                      s_axis_tdata,  // sample_value
    input  logic                             s_axis_tuser,  // func
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [47:0]                      m_axis_tdata,  // row_number, row_product, pad
    output logic                             m_axis_tlast,  // last_row
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [csrmv_pkg::IDX_W-1:0]      cfg_index,
    input  logic [csrmv_pkg::SIZE_W-1:0]     cfg_data
);

    import csrmv_pkg::*;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0] row_count_reg, row_count_next;
    logic [SIZE_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0]  load_row_reg, load_row_next;
    logic [COL_W-1:0]  load_col_reg, load_col_next;
    logic [CNT_W-1:0]  nz_count_reg, nz_count_next;
    logic [COL_W-1:0]  vec_fill_reg, vec_fill_next;
    logic              ready_reg, ready_next;
    logic [ROW_W-1:0]  walk_row_reg, walk_row_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  end_reg, end_next;
    logic              out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [ACC_W-1:0]  out_prod_reg, out_prod_next;
    logic              out_last_reg, out_last_next;

    // memory ports
    logic              nz_we;
    logic [NZ_AW-1:0]  nz_waddr, nz_raddr;
    nz_entry_t         nz_wdata, nz_rdata;
    logic              rs_we;
    logic [ROW_W-1:0]  rs_waddr, rs_raddr;
    logic [CNT_W-1:0]  rs_wdata, rs_rdata;
    logic              vec_we;
    logic [COL_W-1:0]  vec_waddr, vec_raddr;
    logic [VAL_W-1:0]  vec_wdata, vec_rdata;

    mac_ctrl_t         mac_ctrl;
    logic [ACC_W-1:0]  mac_acc;
    logic              mac_busy;

    // load helpers
    logic [ROW_W-1:0]  lr_eff;
    logic [COL_W-1:0]  lc_eff;
    logic [CNT_W-1:0]  cnt_eff;
    logic [SIZE_W-1:0] lc_inc, lr_inc, fill_inc;
    logic              keep_nz, walk_last;
    logic [SIZE_W-1:0] cfg_clamped;

    // stores
    csrmv_ram #(.WIDTH($bits(nz_entry_t)), .DEPTH(MAX_NONZEROS)) u_nz_ram (
        .clk     (clk),
        .wr_en   (nz_we),
        .wr_addr (nz_waddr),
        .wr_data (nz_wdata),
        .rd_addr (nz_raddr),
        .rd_data (nz_rdata)
    );

    csrmv_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ROWS)) u_rs_ram (
        .clk     (clk),
        .wr_en   (rs_we),
        .wr_addr (rs_waddr),
        .wr_data (rs_wdata),
        .rd_addr (rs_raddr),
        .rd_data (rs_rdata)
    );

    csrmv_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLS)) u_vec_ram (
        .clk     (clk),
        .wr_en   (vec_we),
        .wr_addr (vec_waddr),
        .wr_data (vec_wdata),
        .rd_addr (vec_raddr),
        .rd_data (vec_rdata)
    );

    // multiply-accumulate pipeline
    csrmv_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .nz_rdata  (nz_rdata),
        .vec_rdata (vec_rdata),
        .vec_raddr (vec_raddr),
        .acc       (mac_acc),
        .busy      (mac_busy)
    );

    // size clamp for a configuration value
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_clamped = SIZE_W'(1);
        end
        else
        begin
            cfg_clamped = cfg_data;
        end
    end

    // effective load position, restarted when a finished matrix is followed by an entry
    always_comb
    begin
        lr_eff   = ready_reg ? '0 : load_row_reg;
        lc_eff   = ready_reg ? '0 : load_col_reg;
        cnt_eff  = ready_reg ? '0 : nz_count_reg;
        lc_inc   = {1'b0, lc_eff} + SIZE_W'(1);
        lr_inc   = {1'b0, lr_eff} + SIZE_W'(1);
        fill_inc = {1'b0, vec_fill_reg} + SIZE_W'(1);
        keep_nz  = (s_axis_tdata != '0) && !cnt_eff[CNT_W-1];
        walk_last = ({1'b0, walk_row_reg} + SIZE_W'(1)) == row_count_reg;
    end

    // next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        load_row_next  = load_row_reg;
        load_col_next  = load_col_reg;
        nz_count_next  = nz_count_reg;
        vec_fill_next  = vec_fill_reg;
        ready_next     = ready_reg;
        walk_row_next  = walk_row_reg;
        k_next         = k_reg;
        end_next       = end_reg;
        out_valid_next = out_valid_reg;
        out_row_next   = out_row_reg;
        out_prod_next  = out_prod_reg;
        out_last_next  = out_last_reg;

        nz_we     = 1'b0;
        nz_waddr  = cnt_eff[NZ_AW-1:0];
        nz_wdata  = '{col: lc_eff, value: s_axis_tdata};
        nz_raddr  = k_reg[NZ_AW-1:0];
        rs_we     = 1'b0;
        rs_waddr  = lr_eff;
        rs_wdata  = cnt_eff;
        rs_raddr  = ROW_W'({1'b0, walk_row_reg} + SIZE_W'(1));
        vec_we    = 1'b0;
        vec_waddr = vec_fill_reg;
        vec_wdata = s_axis_tdata;
        mac_ctrl  = '{issue: 1'b0, clear: 1'b0};

        cfg_ready     = (state_reg == S_IDLE);
        s_axis_tready = (state_reg == S_IDLE) && !cfg_valid;

        // output register drains on a transaction
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    // a write to the row or column count restarts loading
                    unique case (cfg_index)
                        REG_ROW_COUNT:
                        begin
                            row_count_next = (cfg_clamped > SIZE_W'(MAX_ROWS)) ?
                                             SIZE_W'(MAX_ROWS) : cfg_clamped;
                        end
                        REG_COLUMN_COUNT:
                        begin
                            col_count_next = (cfg_clamped > SIZE_W'(MAX_COLS)) ?
                                             SIZE_W'(MAX_COLS) : cfg_clamped;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (cfg_index == REG_ROW_COUNT || cfg_index == REG_COLUMN_COUNT)
                    begin
                        load_row_next = '0;
                        load_col_next = '0;
                        nz_count_next = '0;
                        vec_fill_next = '0;
                        ready_next    = 1'b0;
                    end
                end
                else if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == ITEM_MATRIX)
                    begin
                        // dense entry, compressed on the fly
                        load_row_next = lr_eff;
                        load_col_next = lc_eff;
                        nz_count_next = cnt_eff;
                        ready_next    = 1'b0;
                        if (ready_reg)
                        begin
                            vec_fill_next = '0;
                        end
                        if ({1'b0, lr_eff} < row_count_reg)
                        begin
                            rs_we = (lc_eff == '0);
                            if (keep_nz)
                            begin
                                nz_we         = 1'b1;
                                nz_count_next = cnt_eff + CNT_W'(1);
                            end
                            if (lc_inc >= col_count_reg)
                            begin
                                load_col_next = '0;
                                if (lr_inc >= row_count_reg)
                                begin
                                    load_row_next = '0;
                                    ready_next    = 1'b1;
                                end
                                else
                                begin
                                    load_row_next = lr_inc[ROW_W-1:0];
                                end
                            end
                            else
                            begin
                                load_col_next = lc_inc[COL_W-1:0];
                            end
                        end
                    end
                    else if (ready_reg)
                    begin
                        // vector element; the last one starts the walk
                        vec_we = 1'b1;
                        if (fill_inc >= col_count_reg)
                        begin
                            vec_fill_next = '0;
                            walk_row_next = '0;
                            k_next        = '0;
                            state_next    = S_ROW;
                        end
                        else
                        begin
                            vec_fill_next = fill_inc[COL_W-1:0];
                        end
                    end
                end
            end
            S_ROW:
            begin
                // start of the next row is being read
                state_next = S_ROWEND;
            end
            S_ROWEND:
            begin
                end_next      = walk_last ? nz_count_reg : rs_rdata;
                mac_ctrl.clear = 1'b1;
                state_next    = S_RUN;
            end
            S_RUN:
            begin
                if (k_reg < end_reg)
                begin
                    mac_ctrl.issue = 1'b1;
                    k_next         = k_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!mac_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = walk_row_reg;
                    out_prod_next  = mac_acc;
                    out_last_next  = walk_last;
                    if (walk_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        walk_row_next = walk_row_reg + ROW_W'(1);
                        state_next    = S_ROW;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_count_reg <= SIZE_W'(1);
            col_count_reg <= SIZE_W'(1);
            load_row_reg  <= '0;
            load_col_reg  <= '0;
            nz_count_reg  <= '0;
            vec_fill_reg  <= '0;
            ready_reg     <= 1'b0;
            walk_row_reg  <= '0;
            k_reg         <= '0;
            end_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            load_row_reg  <= load_row_next;
            load_col_reg  <= load_col_next;
            nz_count_reg  <= nz_count_next;
            vec_fill_reg  <= vec_fill_next;
            ready_reg     <= ready_next;
            walk_row_reg  <= walk_row_next;
            k_reg         <= k_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_row_reg  <= out_row_next;
        out_prod_reg <= out_prod_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_prod_reg, out_row_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule
